// ===== sv/apn_pkg.sv =====
// Shared types, constants and codes of the audio peak normaliser.
package apn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TARGET_BITS = 15;
  localparam int GAIN_FRAC_BITS_DEF = 15;

  localparam logic [TARGET_BITS-1:0] TARGET_RESET = {TARGET_BITS{1'b1}};

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_MEASURE = 2'd1;
  localparam logic [1:0] CMD_SCALE   = 2'd2;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] scaled_sample;
    logic                          clipped;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_WRITE
  } state_t;

endpackage

// ===== sv/audio_peak_normalizer.sv =====
// Top level of the audio peak normaliser: sequencer, state and output register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  sample   | sample_valid / sample_ready | sample_word (cmd, sample)
//  result   | result_valid / result_ready | result_word (scaled_sample, clipped)
//  target   | target_we                   | target_data (target_peak)
//
// A measure word is handled in the idle state. A scale word runs the shift-add
// multiplier; the first scale word of a pass first runs a restoring division
// for the gain (none for zero peak). Both loops share one adder. Reset is
// synchronous; it idles the sequencer, clears peak, gain and result_valid.
// A result waiting in the output register does not block new words; a finished
// scale word waits in the write step until that register is free.
module audio_peak_normalizer #(
  parameter int GAIN_FRAC_BITS = apn_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  apn_pkg::in_word_t                    sample_word,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output apn_pkg::out_word_t                   result_word,
  input  logic                                 target_we,
  input  logic [apn_pkg::TARGET_BITS-1:0]      target_data
);

  localparam int S      = apn_pkg::SAMPLE_BITS;
  localparam int GAIN_W = apn_pkg::TARGET_BITS + GAIN_FRAC_BITS;
  localparam int PW     = GAIN_W + S;
  localparam int QW     = PW - GAIN_FRAC_BITS;
  localparam int ITER   = (GAIN_W > S) ? GAIN_W : S;
  localparam int W      = ITER + 1;
  localparam int CNT_W  = $clog2(ITER);

  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [CNT_W-1:0]  MUL_LAST = CNT_W'(S - 1);
  localparam logic [GAIN_W-1:0] UNITY    = GAIN_W'(1) << GAIN_FRAC_BITS;

  apn_pkg::state_t state, state_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic [S-1:0]               rem, rem_next;
  logic [GAIN_W-1:0]          quo, quo_next;
  logic [PW-1:0]              prod, prod_next;
  logic                       neg, neg_next;
  logic [GAIN_W-1:0]          gain, gain_next;
  logic                       gain_ready, gain_ready_next;
  logic [S-1:0]               peak, peak_next;
  logic [apn_pkg::TARGET_BITS-1:0] target;
  logic                       load_out;
  apn_pkg::out_word_t         sat_word;

  logic [S-1:0] mag;
  logic [S:0]   rem_shift;
  logic [W-1:0] alu_a, alu_b, alu_sum;
  logic         alu_sub, alu_carry;

  // Magnitude in S bits unsigned: the most negative sample maps to 2^(S-1).
  assign mag = sample_word.sample[S-1] ? (~sample_word.sample + S'(1))
                                       : sample_word.sample;
  assign rem_shift = {rem, quo[GAIN_W-1]};
  assign sample_ready = (state == apn_pkg::ST_IDLE);

  always_comb begin
    if (state == apn_pkg::ST_DIV) begin
      alu_a   = W'(rem_shift);
      alu_b   = W'(peak);
      alu_sub = 1'b1;
    end else begin
      alu_a   = W'(prod[PW-1:S]);
      alu_b   = prod[0] ? W'(gain) : '0;
      alu_sub = 1'b0;
    end
  end

  apn_addsub #(.W(W)) u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  apn_sat #(.QW(QW)) u_sat (
    .mag  (prod[PW-1:GAIN_FRAC_BITS]),
    .neg  (neg),
    .word (sat_word)
  );

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    rem_next        = rem;
    quo_next        = quo;
    prod_next       = prod;
    neg_next        = neg;
    gain_next       = gain;
    gain_ready_next = gain_ready;
    peak_next       = peak;
    load_out        = 1'b0;
    case (state)
      apn_pkg::ST_IDLE: begin
        if (sample_valid) begin
          case (sample_word.cmd)
            apn_pkg::CMD_CLEAR: begin
              peak_next       = mag;
              gain_ready_next = 1'b0;
            end
            apn_pkg::CMD_MEASURE: begin
              if (mag > peak) peak_next = mag;
              gain_ready_next = 1'b0;
            end
            apn_pkg::CMD_SCALE: begin
              neg_next  = sample_word.sample[S-1];
              prod_next = {{GAIN_W{1'b0}}, mag};
              if (gain_ready) begin
                cnt_next   = MUL_LAST;
                state_next = apn_pkg::ST_MUL;
              end else if (peak == '0) begin
                gain_next       = UNITY;
                gain_ready_next = 1'b1;
                cnt_next        = MUL_LAST;
                state_next      = apn_pkg::ST_MUL;
              end else begin
                quo_next   = {target, {GAIN_FRAC_BITS{1'b0}}};
                rem_next   = '0;
                cnt_next   = DIV_LAST;
                state_next = apn_pkg::ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      apn_pkg::ST_DIV: begin
        // One quotient bit a cycle; the carry says the shifted remainder fits.
        rem_next = alu_carry ? alu_sum[S-1:0] : rem_shift[S-1:0];
        quo_next = {quo[GAIN_W-2:0], alu_carry};
        if (cnt == '0) begin
          gain_next       = {quo[GAIN_W-2:0], alu_carry};
          gain_ready_next = 1'b1;
          cnt_next        = MUL_LAST;
          state_next      = apn_pkg::ST_MUL;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      apn_pkg::ST_MUL: begin
        prod_next = {alu_sum[GAIN_W:0], prod[S-1:1]};
        if (cnt == '0) begin
          state_next = apn_pkg::ST_WRITE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      apn_pkg::ST_WRITE: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = apn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak         <= '0;
      gain         <= '0;
      gain_ready   <= 1'b0;
      target       <= apn_pkg::TARGET_RESET;
      result_valid <= 1'b0;
    end else begin
      peak       <= peak_next;
      gain       <= gain_next;
      gain_ready <= gain_ready_next;
      if (target_we) target <= target_data;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    rem  <= rem_next;
    quo  <= quo_next;
    prod <= prod_next;
    neg  <= neg_next;
    if (load_out) result_word <= sat_word;
  end

endmodule

// ===== sv/apn_addsub.sv =====
// Shared adder/subtractor used by both the divider and the multiplier steps.
module apn_addsub #(
  parameter int W = apn_pkg::SAMPLE_BITS + apn_pkg::TARGET_BITS + 1
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  // With sub set the carry out is high exactly when a is not below b.
  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
  assign sum   = full[W-1:0];
  assign carry = full[W];

endmodule

// ===== sv/apn_sat.sv =====
// Saturation of the scaled magnitude to a signed sample with a clip flag.
module apn_sat #(
  parameter int QW = apn_pkg::SAMPLE_BITS + apn_pkg::TARGET_BITS
) (
  input  logic [QW-1:0]      mag,
  input  logic               neg,
  output apn_pkg::out_word_t word
);

  localparam int S = apn_pkg::SAMPLE_BITS;
  localparam logic [QW-1:0] POS_MAX = {{(QW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAX = QW'(1) << (S-1);

  logic         clip;
  logic [S-1:0] lim;
  logic [S-1:0] res;

  always_comb begin
    if (neg) begin
      clip = mag > NEG_MAX;
      lim  = clip ? NEG_MAX[S-1:0] : mag[S-1:0];
      res  = ~lim + S'(1);
    end else begin
      clip = mag > POS_MAX;
      lim  = clip ? POS_MAX[S-1:0] : mag[S-1:0];
      res  = lim;
    end
    word.scaled_sample = $signed(res);
    word.clipped       = clip;
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the audio peak normaliser: stimulus, gain model and result checks.
module tb_top;

  localparam int GF = apn_pkg::GAIN_FRAC_BITS_DEF;
  localparam int SB = apn_pkg::SAMPLE_BITS;
  localparam int TB = apn_pkg::TARGET_BITS;
  localparam int GAIN_W = TB + GF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_WORDS = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  apn_pkg::in_word_t sample_word = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  apn_pkg::out_word_t result_word;
  logic target_we = 1'b0;
  logic [TB-1:0] target_data = '0;

  audio_peak_normalizer uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word),
    .target_we    (target_we),
    .target_data  (target_data)
  );

  always #1 clk = ~clk;

  apn_pkg::in_word_t sample_q[$];
  apn_pkg::out_word_t scaled_q[$];

  // Model copy of the normaliser state.
  logic [TB-1:0] target_copy = apn_pkg::TARGET_RESET;
  logic [SB:0] peak_copy = '0;
  logic [GAIN_W-1:0] gain_copy = '0;
  logic gain_valid = 1'b0;

  bit no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;

  task automatic normalise_word(input apn_pkg::in_word_t w);
    logic signed [SB:0] wide;
    logic [SB:0] mag;
    logic [63:0] prod;
    logic [63:0] num;
    apn_pkg::out_word_t res;
    wide = (SB+1)'(w.sample);
    mag = (wide < 0) ? -wide : wide;
    if (w.cmd == apn_pkg::CMD_CLEAR || w.cmd == apn_pkg::CMD_MEASURE) begin
      if (w.cmd == apn_pkg::CMD_CLEAR || mag > peak_copy) peak_copy = mag;
      gain_valid = 1'b0;
    end else if (w.cmd == apn_pkg::CMD_SCALE) begin
      if (!gain_valid) begin
        num = 64'(target_copy) << GF;
        if (peak_copy == 0) gain_copy = GAIN_W'(64'(1) << GF);
        else gain_copy = GAIN_W'(num / 64'(peak_copy));
        gain_valid = 1'b1;
      end
      prod = (64'(mag) * 64'(gain_copy)) >> GF;
      res.clipped = 1'b0;
      if (w.sample < 0) begin
        if (prod > 64'(32768)) begin
          prod = 64'(32768);
          res.clipped = 1'b1;
        end
        res.scaled_sample = -prod[SB-1:0];
      end else begin
        if (prod > 64'(32767)) begin
          prod = 64'(32767);
          res.clipped = 1'b1;
        end
        res.scaled_sample = prod[SB-1:0];
      end
      scaled_q.push_back(res);
    end
  endtask

  // Sender: one word at a time, with a drawn gap after each accepted word.
  always @(posedge clk) begin
    int unsigned g;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(sample_valid && !sample_ready)) begin
      if (sample_valid) begin
        normalise_word(sample_word);
        g = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        g = send_gap;
      end
      if (g == 0 && sample_q.size() != 0) begin
        sample_word <= sample_q.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
        send_gap <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off once enough results have passed.
  always @(posedge clk) begin
    int unsigned g;
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= (hold_left == 1);
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (result_valid && result_ready) begin
      g = no_idle ? 0 : $urandom_range(0, 3);
      result_ready <= (g == 0);
      recv_gap <= g;
    end else if (!result_ready) begin
      if (recv_gap > 1) recv_gap <= recv_gap - 1;
      else result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    apn_pkg::out_word_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen <= results_seen + 1;
      if (scaled_q.size() == 0) begin
        $error("result word with nothing expected: scaled_sample %0d, clipped %0d",
               result_word.scaled_sample, result_word.clipped);
        errors++;
      end else begin
        want = scaled_q.pop_front();
        if (result_word.scaled_sample !== want.scaled_sample) begin
          $error("scaled_sample: expected %0d, actual %0d",
                 want.scaled_sample, result_word.scaled_sample);
          errors++;
        end
        if (result_word.clipped !== want.clipped) begin
          $error("clipped: expected %0d, actual %0d", want.clipped, result_word.clipped);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] s;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: s = -16'sd32768;
          1: s = 16'sd32767;
          2: s = 16'sd0;
          3: s = -16'sd1;
          default: s = 16'sd1;
        endcase
      end
      1, 2: s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
      3: s = $signed(16'($urandom)) >>> 4;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic queue_word(input logic [1:0] c, input logic signed [SB-1:0] s);
    apn_pkg::in_word_t w;
    w.cmd = c;
    w.sample = s;
    sample_q.push_back(w);
  endtask

  // Returns the number of words queued that the block acts upon.
  task automatic queue_pass(output int unsigned n);
    int unsigned nm;
    int unsigned ns;
    logic [1:0] c;
    n = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        c = 2'($urandom_range(0, 3));
        queue_word(c, pick_sample());
        if (c != CMD_UNUSED) n++;
      end
    end else begin
      nm = $urandom_range(0, 15);
      ns = $urandom_range(1, 30);
      queue_word(apn_pkg::CMD_CLEAR, pick_sample());
      n++;
      repeat (nm) begin
        queue_word(apn_pkg::CMD_MEASURE, pick_sample());
        n++;
      end
      repeat (ns) begin
        // Now and then a stray measure word breaks the scale run.
        if ($urandom_range(0, 31) == 0) c = apn_pkg::CMD_MEASURE;
        else if ($urandom_range(0, 15) == 0) c = CMD_UNUSED;
        else c = apn_pkg::CMD_SCALE;
        queue_word(c, pick_sample());
        if (c != CMD_UNUSED) n++;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (sample_q.size() != 0 || sample_valid || scaled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_target(input logic [TB-1:0] v);
    @(posedge clk);
    target_we <= 1'b1;
    target_data <= v;
    target_copy = v;
    @(posedge clk);
    target_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [TB-1:0] targets[8];
    int unsigned got;
    int unsigned count;
    targets = '{15'($urandom_range(0, 32767)), 15'h7FFF, 15'h0000, 15'h0001,
                15'($urandom_range(0, 32767)), 15'h4000,
                15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767))};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Scaling before any measure runs at unity gain.
    queue_word(apn_pkg::CMD_SCALE, 16'sd12345);
    queue_word(apn_pkg::CMD_SCALE, -16'sd32768);
    queue_word(CMD_UNUSED, -16'sd1);
    // The most negative sample gives the largest peak.
    queue_word(apn_pkg::CMD_CLEAR, -16'sd32768);
    queue_word(apn_pkg::CMD_SCALE, 16'sd32767);
    queue_word(apn_pkg::CMD_SCALE, -16'sd32768);
    // A zero peak falls back to unity gain.
    queue_word(apn_pkg::CMD_CLEAR, 16'sd0);
    queue_word(apn_pkg::CMD_SCALE, -16'sd1);
    queue_word(apn_pkg::CMD_CLEAR, 16'sd100);
    queue_word(apn_pkg::CMD_MEASURE, -16'sd50);
    queue_word(apn_pkg::CMD_MEASURE, 16'sd200);
    queue_word(apn_pkg::CMD_MEASURE, 16'sd150);
    queue_word(apn_pkg::CMD_SCALE, 16'sd32767);
    queue_word(apn_pkg::CMD_SCALE, -16'sd32768);
    queue_word(apn_pkg::CMD_SCALE, 16'sd200);
    queue_word(apn_pkg::CMD_SCALE, 16'sd0);
    wait_idle();
    set_target('0);
    queue_word(apn_pkg::CMD_CLEAR, 16'sd1000);
    queue_word(apn_pkg::CMD_SCALE, -16'sd1000);
    wait_idle();
    // A new target leaves the gain already worked out in place until the next measure.
    set_target(15'd1);
    queue_word(apn_pkg::CMD_SCALE, 16'sd32767);
    queue_word(apn_pkg::CMD_MEASURE, -16'sd32768);
    queue_word(apn_pkg::CMD_SCALE, -16'sd32768);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      set_target(targets[p]);
      no_idle = (p % 3 == 2);
      count = 0;
      while (count < PHASE_WORDS) begin
        queue_pass(got);
        count += got;
      end
      wait_idle();
    end

    if (errors == 0 && scaled_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
